FILE: hdl/utf8_byte_sanitizer_core_defines.svh
// ---------------------------------------------------------------------------
// UTF-8 byte sanitizer assertion macros
// Shared concurrent assertion forms used by the sanitizer modules.
// ---------------------------------------------------------------------------
`ifndef UTF8_BYTE_SANITIZER_CORE_DEFINES_SVH
`define UTF8_BYTE_SANITIZER_CORE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define UBS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define UBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ubs_pkg.sv
// ---------------------------------------------------------------------------
// UTF-8 byte sanitizer package
// Types and constants shared by the sanitizer modules, and the front end's lead byte decoder.
// ---------------------------------------------------------------------------
package ubs_pkg;

    localparam int MAX_OUT     = 4;
    localparam int HELD_DEPTH  = 3;
    localparam int CNT_W       = 3;
    localparam int CMDQ_DEPTH  = 2;

    localparam logic [7:0] REPL_RESET = 8'h3F;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte [MAX_OUT-1:0] data;
        logic [CNT_W-1:0]    count;
        logic                last;
    } t_cmd;

    function automatic logic [CNT_W-1:0] lead_length(input t_byte c);
        logic [CNT_W-1:0] len;
        if (c < 8'h80) begin
            len = 3'd1;
        end else if ((c & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((c & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((c & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

FILE: hdl/ubs_front.sv
// ---------------------------------------------------------------------------
// UTF-8 byte sanitizer front end
// Accepts input bytes, tracks the pending sequence and builds output commands
// of up to four bytes, at most one per accepted input byte.
// ---------------------------------------------------------------------------
`include "utf8_byte_sanitizer_core_defines.svh"

module ubs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  ubs_pkg::t_byte i_cfg_wdata,
    input  logic          i_accept,
    input  ubs_pkg::t_byte i_data_byte,
    input  logic          i_end_of_string,
    output logic          o_cmd_push,
    output ubs_pkg::t_cmd o_cmd
);
    import ubs_pkg::*;

    t_byte            r_repl;
    t_byte            r_held [HELD_DEPTH];
    t_byte            n_held [HELD_DEPTH];
    logic [1:0]       r_hc, n_hc;
    logic [CNT_W-1:0] r_exp, n_exp;
    logic [CNT_W-1:0] hc_ext;
    logic [CNT_W-1:0] len;
    logic             cont;
    t_byte            tail;
    t_cmd             cmd;

    assign hc_ext = {1'b0, r_hc};
    assign len    = lead_length(i_data_byte);
    assign cont   = (i_data_byte & CONT_MASK) == CONT_CODE;
    assign tail   = (len == 3'd1) ? i_data_byte : r_repl;

    always_comb begin
        n_held = r_held;
        n_hc   = r_hc;
        n_exp  = r_exp;
        cmd    = '0;
        cmd.last = i_end_of_string;
        priority if (r_hc != 2'd0 && cont) begin
            priority if (hc_ext + 3'd1 == r_exp) begin
                for (int k = 0; k < HELD_DEPTH; k++) begin
                    cmd.data[k] = (3'(k) < hc_ext) ? r_held[k] : i_data_byte;
                end
                cmd.data[MAX_OUT-1] = i_data_byte;
                cmd.count = hc_ext + 3'd1;
                n_hc  = 2'd0;
                n_exp = '0;
            end else if (i_end_of_string || r_hc == 2'd3) begin
                for (int k = 0; k < MAX_OUT; k++) begin
                    cmd.data[k] = r_repl;
                end
                cmd.count = hc_ext + 3'd1;
                n_hc  = 2'd0;
                n_exp = '0;
            end else begin
                n_held[r_hc] = i_data_byte;
                n_hc = r_hc + 2'd1;
            end
        end else begin
            for (int k = 0; k < HELD_DEPTH; k++) begin
                cmd.data[k] = (3'(k) < hc_ext) ? r_repl : tail;
            end
            cmd.data[MAX_OUT-1] = tail;
            n_hc  = 2'd0;
            n_exp = '0;
            priority if (len == 3'd1 || len == 3'd0 || i_end_of_string) begin
                cmd.count = hc_ext + 3'd1;
            end else begin
                cmd.count = hc_ext;
                n_held[0] = i_data_byte;
                n_hc  = 2'd1;
                n_exp = len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= REPL_RESET;
            r_hc   <= 2'd0;
            r_exp  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_repl <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_hc  <= n_hc;
                r_exp <= n_exp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

    assign o_cmd_push = i_accept && (cmd.count != '0);
    assign o_cmd      = cmd;

    `UBS_ASSERT_ALWAYS(a_exp_range, i_clk, i_rst_n,
        (r_hc == 2'd0) || ({1'b0, r_hc} < r_exp && r_exp <= 3'd4),
        "Pending count does not fit the expected sequence length.")
    `UBS_ASSERT_NEXT(a_eos_idle, i_clk, i_rst_n, i_accept && i_end_of_string,
        r_hc == 2'd0, "End of string left a pending sequence.")

endmodule

FILE: hdl/ubs_cmdq.sv
// ---------------------------------------------------------------------------
// UTF-8 byte sanitizer command queue
// Short queue of output commands between the front end and the back end.
// ---------------------------------------------------------------------------
`include "utf8_byte_sanitizer_core_defines.svh"

module ubs_cmdq #(
    parameter int DEPTH = ubs_pkg::CMDQ_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ubs_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ubs_pkg::t_cmd o_data
);
    import ubs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [CNT_QW-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = r_cnt == CNT_QW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `UBS_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full),
        "Command pushed into a full queue.")

endmodule

FILE: hdl/ubs_back.sv
// ---------------------------------------------------------------------------
// UTF-8 byte sanitizer back end
// Takes commands from the queue and presents their bytes one per transfer.
// ---------------------------------------------------------------------------
`include "utf8_byte_sanitizer_core_defines.svh"

module ubs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ubs_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output ubs_pkg::t_byte o_out_byte,
    output logic          o_out_last
);
    import ubs_pkg::*;

    logic       r_valid;
    t_cmd       r_cmd;
    logic [1:0] r_idx;
    logic       at_end;
    logic       load;

    assign at_end  = ({1'b0, r_idx} + 3'd1) == r_cmd.count;
    assign load    = !r_valid || (i_pop && at_end);
    assign o_q_pop = load && i_q_valid;

    assign o_empty    = !r_valid;
    assign o_out_byte = r_cmd.data[r_idx];
    assign o_out_last = r_cmd.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_q_valid;
            r_idx   <= 2'd0;
        end else if (i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_data;
        end
    end

    `UBS_ASSERT_ALWAYS(a_cmd_nonempty, i_clk, i_rst_n,
        !r_valid || (r_cmd.count != '0 && r_cmd.count <= 3'd4),
        "Held command has no bytes to transfer.")
    `UBS_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, r_valid && i_pop && !at_end,
        r_valid && r_idx == $past(r_idx) + 2'd1,
        "Output index did not advance after a transfer.")

endmodule

FILE: hdl/utf8_byte_sanitizer_core.sv
// ---------------------------------------------------------------------------
// UTF-8 byte sanitizer core
// Repairs a UTF-8 byte stream: complete sequences pass, broken ones become
// replacement bytes. A front end classifies bytes, a back end emits them.
//
//   Channel   Handshake          Payload
//   input     push / full        i_data_byte, i_end_of_string
//   result    empty / pop        o_out_byte, o_out_last
//   config    i_cfg_we           i_cfg_wdata (replacement byte)
//
// An input byte causes zero to four results.
// The back end emits one result per cycle while pop is high, so input runs at
// one byte per cycle while bytes average at most one result each, else at the
// result rate; input stalls only when the queue (CMDQ_DEPTH entries) is full.
// The first result of a byte passes the command queue and the back end's command register.
// Reset is synchronous, active low, and sets the replacement byte to '?'.
// ---------------------------------------------------------------------------
module utf8_byte_sanitizer_core #(
    parameter int CMDQ_DEPTH = ubs_pkg::CMDQ_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  ubs_pkg::t_byte i_cfg_wdata,
    input  logic           push,
    output logic           full,
    input  ubs_pkg::t_byte i_data_byte,
    input  logic           i_end_of_string,
    output logic           empty,
    input  logic           pop,
    output ubs_pkg::t_byte o_out_byte,
    output logic           o_out_last
);
    import ubs_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_data;

    assign accept = push && !full;

    ubs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd)
    );

    ubs_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    ubs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule
